@@ src/lcbw_pkg.sv @@
`default_nettype none

package lcbw_pkg;

    // filter type codes
    localparam logic [1:0] FT_LOWPASS  = 2'd0;
    localparam logic [1:0] FT_HIGHPASS = 2'd1;
    localparam logic [1:0] FT_BANDPASS = 2'd2;
    localparam logic [1:0] FT_BANDSTOP = 2'd3;

    // ladder order codes
    localparam logic [1:0] ORDER_2 = 2'd2;
    localparam logic [1:0] ORDER_3 = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FILTER_TYPE  = 3'd0;
    localparam logic [2:0] REG_FILTER_ORDER = 3'd1;
    localparam logic [2:0] REG_CUTOFF       = 3'd2;
    localparam logic [2:0] REG_TERMINATION  = 3'd3;
    localparam logic [2:0] REG_BANDWIDTH    = 3'd4;

    localparam logic [10:0] SQ2_NUM     = 11'd1414;
    localparam logic [9:0]  SQ2_DEN     = 10'd1000;
    localparam logic [18:0] HALF_SQ_NUM = 19'd499849;
    localparam logic [18:0] HALF_SQ_DEN = 19'd500000;

    localparam int CORDIC_N = 18;
    localparam int CX_W     = 44;
    localparam int ANG_W    = 27;

    localparam logic signed [ANG_W-1:0] DEG90_UNITS = 27'sd9216000;
    localparam logic [14:0] PHASE_LIMIT = 15'd18000;

    // arctangent of 2^-i in 1/1024 centidegree
    localparam logic [22:0] ATAN_TAB [CORDIC_N] = '{
        23'd4608000, 23'd2720261, 23'd1437311, 23'd729602, 23'd366217, 23'd183287,
        23'd91666, 23'd45836, 23'd22918, 23'd11459, 23'd5730, 23'd2865,
        23'd1432, 23'd716, 23'd358, 23'd179, 23'd90, 23'd45
    };

    typedef struct packed {
        logic [1:0]  filter_type;
        logic [1:0]  filter_order;
        logic [31:0] cutoff_hz;
        logic [31:0] bandwidth_hz;
    } cfg_t;

    // number of significant bits
    function automatic logic [6:0] bitlen64(input logic [63:0] v);
        logic [6:0] bl;
        bl = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                bl = 7'(i + 1);
            end
        end
        return bl;
    endfunction

    // arithmetic shift right rounding toward zero
    function automatic logic signed [CX_W-1:0] tshr(input logic signed [CX_W-1:0] v,
                                                     input int unsigned s);
        logic signed [CX_W-1:0] fl;
        logic [CX_W-1:0] mask;
        fl = v >>> s;
        mask = (CX_W'(1) << s) - CX_W'(1);
        return (v[CX_W-1] && ((v & mask) != '0)) ? fl + CX_W'(1) : fl;
    endfunction

endpackage

`default_nettype wire

@@ src/lcbw_if.sv @@
`default_nettype none

interface lcbw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] probe_hz;
    modport source (output valid, output probe_hz, input ready);
    modport sink (input valid, input probe_hz, output ready);
endinterface

interface lcbw_out_if;
    logic               valid;
    logic               ready;
    logic [16:0]        gain;
    logic signed [15:0] phase_centideg;
    logic               status;
    modport source (output valid, output gain, output phase_centideg, output status,
                    input ready);
    modport sink (input valid, input gain, input phase_centideg, input status,
                  output ready);
endinterface

`default_nettype wire

@@ src/lc_butterworth_response_unit.sv @@
// Butterworth LC ladder response evaluator.
// probe channel: one word per probe frequency in hertz (0 is taken as 1).
// resp channel: one word per probe, in order: gain (twice the transfer
// magnitude, Q1.16, at most 1.0), phase in centidegrees (low-pass and
// high-pass only, else 0) and status (1 for an unsupported type and order,
// with gain and phase 0).
// The ladder is set through the APB port: type, order, cutoff, termination
// and bandwidth at byte addresses 0, 4, 8, 12 and 16; writes while idle only.
// One probe per cycle while not stalled; each passes the front stages,
// the 31-stage square root, the 17-stage quotient and the output stage.
// The whole pipeline advances together: it moves whenever the output
// register is empty or being taken, so a stalled receiver freezes every
// stage and drops probe.ready until the held word is taken.
// Reset clears all valid bits and loads the registers with low-pass,
// order 2, cutoff 1000, termination 50 and bandwidth 100.
`default_nettype none

module lc_butterworth_response_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    lcbw_in_if.sink          probe,
    lcbw_out_if.source       resp
);

    logic [1:0]  filter_type_reg;
    logic [1:0]  filter_order_reg;
    logic [31:0] cutoff_hz_reg;
    logic [15:0] termination_ohms_reg;
    logic [31:0] bandwidth_hz_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_type_reg      <= lcbw_pkg::FT_LOWPASS;
            filter_order_reg     <= lcbw_pkg::ORDER_2;
            cutoff_hz_reg        <= 32'd1000;
            termination_ohms_reg <= 16'd50;
            bandwidth_hz_reg     <= 32'd100;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lcbw_pkg::REG_FILTER_TYPE:  filter_type_reg      <= pwdata[1:0];
                lcbw_pkg::REG_FILTER_ORDER: filter_order_reg     <= pwdata[1:0];
                lcbw_pkg::REG_CUTOFF:       cutoff_hz_reg        <= pwdata;
                lcbw_pkg::REG_TERMINATION:  termination_ohms_reg <= pwdata[15:0];
                lcbw_pkg::REG_BANDWIDTH:    bandwidth_hz_reg     <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lcbw_pkg::REG_FILTER_TYPE:  prdata = {30'b0, filter_type_reg};
            lcbw_pkg::REG_FILTER_ORDER: prdata = {30'b0, filter_order_reg};
            lcbw_pkg::REG_CUTOFF:       prdata = cutoff_hz_reg;
            lcbw_pkg::REG_TERMINATION:  prdata = {16'b0, termination_ohms_reg};
            lcbw_pkg::REG_BANDWIDTH:    prdata = bandwidth_hz_reg;
            default:                    prdata = '0;
        endcase
    end

    lcbw_pkg::cfg_t cfg;
    logic           adv;
    logic           out_valid;

    assign cfg.filter_type  = filter_type_reg;
    assign cfg.filter_order = filter_order_reg;
    assign cfg.cutoff_hz    = cutoff_hz_reg;
    assign cfg.bandwidth_hz = bandwidth_hz_reg;

    // pipeline moves unless a finished word is held
    assign adv         = !out_valid || resp.ready;
    assign probe.ready = adv;
    assign resp.valid  = out_valid;

    lcbw_pipe u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_valid       (probe.valid),
        .probe_hz       (probe.probe_hz),
        .cfg            (cfg),
        .out_valid      (out_valid),
        .gain           (resp.gain),
        .phase_centideg (resp.phase_centideg),
        .status         (resp.status)
    );

endmodule

`default_nettype wire

@@ src/lcbw_pipe.sv @@
`default_nettype none

module lcbw_pipe (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [31:0]         probe_hz,
    input  wire lcbw_pkg::cfg_t      cfg,
    output logic                     out_valid,
    output logic [16:0]              gain,
    output logic signed [15:0]       phase_centideg,
    output logic                     status
);

    localparam int FRONT_N = 10;
    localparam int SQ_N    = 31;
    localparam int DV_N    = 17;
    localparam int CD_N    = lcbw_pkg::CORDIC_N;
    localparam int PH_N    = CD_N + 3;
    localparam int DLY_N   = SQ_N + DV_N - PH_N;
    localparam int TOTAL_N = FRONT_N + SQ_N + DV_N + 1;
    localparam int CW      = lcbw_pkg::CX_W;
    localparam int AW      = lcbw_pkg::ANG_W;

    logic [31:0] c_eff, bw_eff;
    logic        is_o2, is_lp, is_hp, ok;

    assign c_eff  = (cfg.cutoff_hz == '0) ? 32'd1 : cfg.cutoff_hz;
    assign bw_eff = (cfg.bandwidth_hz == '0) ? 32'd1 : cfg.bandwidth_hz;
    assign is_o2  = (cfg.filter_order == lcbw_pkg::ORDER_2);
    assign is_lp  = (cfg.filter_type == lcbw_pkg::FT_LOWPASS);
    assign is_hp  = (cfg.filter_type == lcbw_pkg::FT_HIGHPASS);
    assign ok     = (cfg.filter_order == lcbw_pkg::ORDER_3) || ((is_lp || is_hp) && is_o2);

    // valid bits travel with the words
    logic [TOTAL_N-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_N-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[TOTAL_N-1];

    // front stages
    logic [31:0] p1_reg, p2_reg;
    logic [63:0] pp2_reg, cc2_reg, bp2_reg;
    logic [63:0] tn3_reg, td3_reg, tn4_reg, td4_reg;
    logic [5:0]  sh4_reg;
    logic [19:0] tn5_reg, td5_reg, tn6_reg, td6_reg;
    logic [30:0] a6_reg;
    logic [29:0] b6_reg;
    logic [39:0] tn2_6_reg, td2_6_reg, tntd6_reg;
    logic [59:0] wn7_reg, wd7_reg, wn8_reg, wd8_reg;
    logic [61:0] m1_7_reg, m2_7_reg, m3_7_reg;
    logic signed [63:0] re8_reg, im8_reg;
    logic [5:0]  wsh8_reg;
    logic [19:0] wn9_reg, wd9_reg, wd10_reg;
    logic [62:0] rm9_reg, im9_reg, rm10_reg, im10_reg;
    logic        rneg9_reg, ineg9_reg, zero9_reg, rneg10_reg, ineg10_reg, zero10_reg;
    logic [60:0] v10_reg;
    logic [4:0]  csh10_reg;

    logic [63:0] diff3, tn3_next, td3_next;
    logic [6:0]  bl4, wbl8, cbl10;
    logic signed [63:0] re8_next, im8_next;
    logic [40:0] sum10;

    always_comb
    begin
        diff3 = (pp2_reg > cc2_reg) ? pp2_reg - cc2_reg : cc2_reg - pp2_reg;
        case (cfg.filter_type)
            lcbw_pkg::FT_LOWPASS:
            begin
                tn3_next = 64'(p2_reg);
                td3_next = 64'(c_eff);
            end
            lcbw_pkg::FT_HIGHPASS:
            begin
                tn3_next = 64'(c_eff);
                td3_next = 64'(p2_reg);
            end
            lcbw_pkg::FT_BANDPASS:
            begin
                tn3_next = diff3;
                td3_next = bp2_reg;
            end
            default:
            begin
                tn3_next = bp2_reg;
                td3_next = diff3;
            end
        endcase
    end

    assign bl4 = lcbw_pkg::bitlen64(tn3_reg | td3_reg);
    assign wbl8 = lcbw_pkg::bitlen64({4'b0, wn7_reg | wd7_reg});
    assign cbl10 = lcbw_pkg::bitlen64({1'b0, rm9_reg | im9_reg});

    always_comb
    begin
        if (is_o2)
        begin
            im8_next = $signed({1'b0, m3_7_reg, 1'b0});
            re8_next = $signed({1'b0, m2_7_reg, 1'b0}) - $signed({2'b0, m1_7_reg});
        end
        else
        begin
            im8_next = $signed({1'b0, m2_7_reg, 1'b0}) - $signed({4'b0, wn7_reg});
            re8_next = $signed({4'b0, wd7_reg}) - $signed({1'b0, m1_7_reg, 1'b0});
        end
    end

    assign sum10 = 41'(64'(wn9_reg) * 64'(wn9_reg)) + 41'(64'(wd9_reg) * 64'(wd9_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= (probe_hz == '0) ? 32'd1 : probe_hz;

            pp2_reg   <= 64'(p1_reg) * 64'(p1_reg);
            cc2_reg   <= 64'(c_eff) * 64'(c_eff);
            bp2_reg   <= 64'(bw_eff) * 64'(p1_reg);
            p2_reg    <= p1_reg;

            tn3_reg   <= tn3_next;
            td3_reg   <= td3_next;

            sh4_reg   <= (bl4 > 7'd20) ? 6'(bl4 - 7'd20) : 6'd0;
            tn4_reg   <= tn3_reg;
            td4_reg   <= td3_reg;

            tn5_reg   <= 20'(tn4_reg >> sh4_reg);
            td5_reg   <= 20'(td4_reg >> sh4_reg);

            a6_reg    <= 31'(64'(tn5_reg) * 64'(lcbw_pkg::SQ2_NUM));
            b6_reg    <= 30'(64'(td5_reg) * 64'(lcbw_pkg::SQ2_DEN));
            tn2_6_reg <= 40'(64'(tn5_reg) * 64'(tn5_reg));
            td2_6_reg <= 40'(64'(td5_reg) * 64'(td5_reg));
            tntd6_reg <= 40'(64'(tn5_reg) * 64'(td5_reg));
            tn6_reg   <= tn5_reg;
            td6_reg   <= td5_reg;

            wn7_reg   <= is_o2 ? 60'(64'(lcbw_pkg::HALF_SQ_NUM) * 64'(tn2_6_reg))
                               : 60'(64'(tn2_6_reg) * 64'(tn6_reg));
            wd7_reg   <= is_o2 ? 60'(64'(lcbw_pkg::HALF_SQ_DEN) * 64'(td2_6_reg))
                               : 60'(64'(td2_6_reg) * 64'(td6_reg));
            m1_7_reg  <= is_o2 ? 62'(64'(a6_reg) * 64'(a6_reg))
                               : 62'(64'(tn2_6_reg) * 64'(td6_reg));
            m2_7_reg  <= is_o2 ? 62'(64'(b6_reg) * 64'(b6_reg))
                               : 62'(64'(tntd6_reg) * 64'(td6_reg));
            m3_7_reg  <= 62'(64'(a6_reg) * 64'(b6_reg));

            re8_reg   <= re8_next;
            im8_reg   <= im8_next;
            wsh8_reg  <= (wbl8 > 7'd20) ? 6'(wbl8 - 7'd20) : 6'd0;
            wn8_reg   <= wn7_reg;
            wd8_reg   <= wd7_reg;

            wn9_reg   <= 20'(wn8_reg >> wsh8_reg);
            wd9_reg   <= 20'(wd8_reg >> wsh8_reg);
            rm9_reg   <= re8_reg[63] ? 63'(-re8_reg) : re8_reg[62:0];
            im9_reg   <= im8_reg[63] ? 63'(-im8_reg) : im8_reg[62:0];
            rneg9_reg <= re8_reg[63];
            ineg9_reg <= im8_reg[63];
            zero9_reg <= (re8_reg == '0) && (im8_reg == '0);

            v10_reg    <= {sum10, 20'b0};
            wd10_reg   <= wd9_reg;
            csh10_reg  <= (cbl10 > 7'd40) ? 5'(cbl10 - 7'd40) : 5'd0;
            rm10_reg   <= rm9_reg;
            im10_reg   <= im9_reg;
            rneg10_reg <= rneg9_reg;
            ineg10_reg <= ineg9_reg;
            zero10_reg <= zero9_reg;
        end
    end

    // floor square root, one result bit per stage
    logic [61:0] sqv_reg [SQ_N];
    logic [61:0] sqr_reg [SQ_N];
    logic [19:0] sqw_reg [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        logic [61:0] v_in, r_in, bit_k, trial;
        logic [19:0] w_in;

        if (k == 0)
        begin : g_first
            assign v_in = {1'b0, v10_reg};
            assign r_in = '0;
            assign w_in = wd10_reg;
        end
        else
        begin : g_rest
            assign v_in = sqv_reg[k-1];
            assign r_in = sqr_reg[k-1];
            assign w_in = sqw_reg[k-1];
        end

        assign bit_k = 62'(1) << (2 * (SQ_N - 1 - k));
        assign trial = r_in + bit_k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    sqv_reg[k] <= v_in - trial;
                    sqr_reg[k] <= (r_in >> 1) + bit_k;
                end
                else
                begin
                    sqv_reg[k] <= v_in;
                    sqr_reg[k] <= r_in >> 1;
                end
                sqw_reg[k] <= w_in;
            end
        end
    end

    // restoring division wd*2^26 / sqrt, quotient never above 2^16
    logic [45:0] dvr_reg [DV_N];
    logic [16:0] dvq_reg [DV_N];
    logic [30:0] dvd_reg [DV_N];
    logic        dvz_reg [DV_N];

    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        logic [45:0] r_in;
        logic [16:0] q_in;
        logic [30:0] d_in;
        logic        z_in;
        logic [47:0] dsh;

        if (j == 0)
        begin : g_first
            logic [30:0] sq_fin;
            assign sq_fin = sqr_reg[SQ_N-1][30:0];
            assign r_in = {sqw_reg[SQ_N-1], 26'b0};
            assign q_in = '0;
            assign d_in = sq_fin;
            assign z_in = (sqw_reg[SQ_N-1] == '0) || (sq_fin == '0);
        end
        else
        begin : g_rest
            assign r_in = dvr_reg[j-1];
            assign q_in = dvq_reg[j-1];
            assign d_in = dvd_reg[j-1];
            assign z_in = dvz_reg[j-1];
        end

        assign dsh = 48'(d_in) << (DV_N - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (48'(r_in) >= dsh)
                begin
                    dvr_reg[j] <= 46'(48'(r_in) - dsh);
                    dvq_reg[j] <= q_in | (17'(1) << (DV_N - 1 - j));
                end
                else
                begin
                    dvr_reg[j] <= r_in;
                    dvq_reg[j] <= q_in;
                end
                dvd_reg[j] <= d_in;
                dvz_reg[j] <= z_in;
            end
        end
    end

    // phase: scale, quadrant fold, cordic vectoring, rounding
    logic signed [CW-1:0] x11_reg, y11_reg;
    logic                 zero11_reg;
    logic signed [CW-1:0] cx_reg [CD_N+1];
    logic signed [CW-1:0] cy_reg [CD_N+1];
    logic signed [AW-1:0] ca_reg [CD_N+1];
    logic                 cz_reg [CD_N+1];
    logic [39:0]          xs11, ys11;

    assign xs11 = 40'(rm10_reg >> csh10_reg);
    assign ys11 = 40'(im10_reg >> csh10_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x11_reg    <= rneg10_reg ? -$signed({4'b0, xs11}) : $signed({4'b0, xs11});
            y11_reg    <= ineg10_reg ? -$signed({4'b0, ys11}) : $signed({4'b0, ys11});
            zero11_reg <= zero10_reg;

            if (x11_reg < 0)
            begin
                if (y11_reg >= 0)
                begin
                    cx_reg[0] <= y11_reg;
                    cy_reg[0] <= -x11_reg;
                    ca_reg[0] <= lcbw_pkg::DEG90_UNITS;
                end
                else
                begin
                    cx_reg[0] <= -y11_reg;
                    cy_reg[0] <= x11_reg;
                    ca_reg[0] <= -lcbw_pkg::DEG90_UNITS;
                end
            end
            else
            begin
                cx_reg[0] <= x11_reg;
                cy_reg[0] <= y11_reg;
                ca_reg[0] <= '0;
            end
            cz_reg[0] <= zero11_reg;
        end
    end

    for (genvar i = 0; i < CD_N; i++)
    begin : g_cordic
        logic signed [CW-1:0] dx, dy;
        logic signed [AW-1:0] at;

        assign dx = lcbw_pkg::tshr(cy_reg[i], i);
        assign dy = lcbw_pkg::tshr(cx_reg[i], i);
        assign at = $signed({4'b0, lcbw_pkg::ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    ca_reg[i+1] <= ca_reg[i] + at;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    ca_reg[i+1] <= ca_reg[i] - at;
                end
                cz_reg[i+1] <= cz_reg[i];
            end
        end
    end

    logic signed [AW-1:0] ang_fin;
    logic [AW-1:0]        ang_mag;
    logic [AW-1:0]        ang_rnd;
    logic [14:0]          ang_clip;
    logic signed [15:0]   ang_cd, phr_next;

    always_comb
    begin
        ang_fin  = ca_reg[CD_N];
        ang_mag  = ang_fin[AW-1] ? AW'(-ang_fin) : AW'(ang_fin);
        ang_rnd  = (ang_mag + AW'(512)) >> 10;
        ang_clip = (ang_rnd > AW'(lcbw_pkg::PHASE_LIMIT)) ? lcbw_pkg::PHASE_LIMIT
                                                         : ang_rnd[14:0];
        ang_cd   = ang_fin[AW-1] ? -$signed({1'b0, ang_clip}) : $signed({1'b0, ang_clip});
        if (cz_reg[CD_N])
        begin
            phr_next = '0;
        end
        else
        begin
            phr_next = is_lp ? -ang_cd : ang_cd;
        end
    end

    // phase waits here for the gain path
    logic signed [15:0] phr_reg;
    logic signed [15:0] phd_reg [DLY_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phr_reg <= phr_next;
            for (int n = 0; n < DLY_N; n++)
            begin
                phd_reg[n] <= (n == 0) ? phr_reg : phd_reg[(n == 0) ? 0 : n - 1];
            end
        end
    end

    // output register
    logic [16:0]        gain_reg;
    logic signed [15:0] phase_reg;
    logic               status_reg;
    logic [16:0]        q_fin;

    assign q_fin = dvq_reg[DV_N-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!ok || dvz_reg[DV_N-1])
            begin
                gain_reg <= '0;
            end
            else
            begin
                gain_reg <= (q_fin > 17'd65536) ? 17'd65536 : q_fin;
            end
            phase_reg  <= (ok && (is_lp || is_hp)) ? phd_reg[DLY_N-1] : 16'sd0;
            status_reg <= !ok;
        end
    end

    assign gain           = gain_reg;
    assign phase_centideg = phase_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

@@ src/lcbw_checker.sv @@
`default_nettype none

module lcbw_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [16:0]        gain,
    input wire logic signed [15:0] phase_centideg,
    input wire logic               status
);

    // a held word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gain) &&
        $stable(phase_centideg) && $stable(status))
        else $error("result word changed while stalled");

    // input is only refused while a word is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    a_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain <= 17'd65536)
        else $error("gain above unity");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase_centideg <= 16'sd18000) && (phase_centideg >= -16'sd18000))
        else $error("phase out of range");

    a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (gain == '0) && (phase_centideg == 16'sd0))
        else $error("unsupported result not cleared");

endmodule

bind lc_butterworth_response_unit lcbw_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (probe.ready),
    .out_valid      (resp.valid),
    .out_ready      (resp.ready),
    .gain           (resp.gain),
    .phase_centideg (resp.phase_centideg),
    .status         (resp.status)
);

`default_nettype wire

@@ dv/tb_lc_butterworth_response_unit.sv @@
`default_nettype none

module tb_lc_butterworth_response_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [16:0] gain;
        logic [15:0] phase;
        logic        status;
    } resp_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcbw_in_if  probe ();
    lcbw_out_if resp ();

    lc_butterworth_response_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .probe   (probe.sink),
        .resp    (resp.source)
    );

    // shadow copy of the ladder registers
    logic [1:0]  ladder_type;
    logic [1:0]  ladder_order;
    logic [31:0] ladder_cutoff;
    logic [15:0] ladder_term;
    logic [31:0] ladder_bw;

    logic [31:0] pending_probes [$];
    resp_word_t  expected_resp [$];
    int          error_count;
    int          resp_count;
    int          unsupported_count;
    int          phase_count;
    bit          idle_enable;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // cordic vectoring, result in centidegrees
    function automatic int vector_angle(input longint im, input longint re);
        longint x;
        longint y;
        longint ang;
        longint nx;
        longint dx;
        longint dy;
        x = re;
        y = im;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        while (abs64(x) >= (64'sd1 <<< 40) || abs64(y) >= (64'sd1 <<< 40))
        begin
            x = x / 2;
            y = y / 2;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y;
                y = -x;
                x = nx;
                ang = 9216000;
            end
            else
            begin
                nx = -y;
                y = x;
                x = nx;
                ang = -9216000;
            end
        end
        for (int i = 0; i < lcbw_pkg::CORDIC_N; i++)
        begin
            dx = y / (64'sd1 <<< i);
            dy = x / (64'sd1 <<< i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + longint'(lcbw_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - longint'(lcbw_pkg::ATAN_TAB[i]);
            end
        end
        if (ang >= 0)
            ang = (ang + 512) / 1024;
        else
            ang = -((-ang + 512) / 1024);
        if (ang > 18000)
            ang = 18000;
        if (ang < -18000)
            ang = -18000;
        return int'(ang);
    endfunction

    function automatic resp_word_t ladder_response(input logic [31:0] probe_hz);
        resp_word_t r;
        longint unsigned p;
        longint unsigned c;
        longint unsigned bw;
        longint unsigned diff;
        longint unsigned tn;
        longint unsigned td;
        longint unsigned wn;
        longint unsigned wd;
        longint unsigned sq;
        longint unsigned g;
        longint unsigned a;
        longint unsigned b;
        longint re;
        longint im;
        int ang;
        r.gain = '0;
        r.phase = '0;
        r.status = 1'b0;
        p = (probe_hz == 0) ? 1 : probe_hz;
        c = (ladder_cutoff == 0) ? 1 : ladder_cutoff;
        bw = (ladder_bw == 0) ? 1 : ladder_bw;
        if (!(ladder_order == lcbw_pkg::ORDER_3 ||
              (ladder_type <= lcbw_pkg::FT_HIGHPASS && ladder_order == lcbw_pkg::ORDER_2)))
        begin
            r.status = 1'b1;
            return r;
        end
        diff = (p > c) ? p * p - c * c : c * c - p * p;
        case (ladder_type)
            lcbw_pkg::FT_LOWPASS:
            begin
                tn = p;
                td = c;
            end
            lcbw_pkg::FT_HIGHPASS:
            begin
                tn = c;
                td = p;
            end
            lcbw_pkg::FT_BANDPASS:
            begin
                tn = diff;
                td = bw * p;
            end
            default:
            begin
                tn = bw * p;
                td = diff;
            end
        endcase
        while ((tn >> 20) != 0 || (td >> 20) != 0)
        begin
            tn = tn >> 1;
            td = td >> 1;
        end
        if (ladder_order == lcbw_pkg::ORDER_2)
        begin
            wn = 64'(lcbw_pkg::HALF_SQ_NUM) * tn * tn;
            wd = 64'(lcbw_pkg::HALF_SQ_DEN) * td * td;
        end
        else
        begin
            wn = tn * tn * tn;
            wd = td * td * td;
        end
        while ((wn >> 20) != 0 || (wd >> 20) != 0)
        begin
            wn = wn >> 1;
            wd = wd >> 1;
        end
        sq = floor_sqrt((wn * wn + wd * wd) << 20);
        g = (wd == 0 || sq == 0) ? 0 : (wd << 26) / sq;
        if (g > 65536)
            g = 65536;
        r.gain = g[16:0];
        if (ladder_type <= lcbw_pkg::FT_HIGHPASS)
        begin
            if (ladder_order == lcbw_pkg::ORDER_2)
            begin
                a = 64'(lcbw_pkg::SQ2_NUM) * tn;
                b = 64'(lcbw_pkg::SQ2_DEN) * td;
                im = longint'(2 * a * b);
                re = longint'(2 * b * b) - longint'(a * a);
            end
            else
            begin
                im = longint'(2 * tn * td * td) - longint'(tn * tn * tn);
                re = longint'(td * td * td) - longint'(2 * tn * tn * td);
            end
            ang = vector_angle(im, re);
            if (ladder_type == lcbw_pkg::FT_LOWPASS)
                ang = -ang;
            r.phase = ang[15:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (!idle_enable || roll < 65)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // probe driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe.valid <= 1'b0;
            probe.probe_hz <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (probe.valid && probe.ready)
                expected_resp.push_back(ladder_response(probe.probe_hz));
            if (!probe.valid || probe.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    probe.valid <= 1'b0;
                end
                else if (pending_probes.size() != 0)
                begin
                    probe.valid <= 1'b1;
                    probe.probe_hz <= pending_probes.pop_front();
                    send_gap <= pick_gap();
                end
                else
                begin
                    probe.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on response %0d: %s got %0h want %0h", resp_count, what, got, want);
        error_count++;
    endtask

    // response monitor
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        resp_word_t want;
        if (!rst_n)
        begin
            resp.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (resp.valid && resp.ready)
            begin
                if (expected_resp.size() == 0)
                begin
                    report_mismatch("unexpected word", 32'(resp.gain), 32'd0);
                end
                else
                begin
                    want = expected_resp.pop_front();
                    if (resp.gain !== want.gain)
                        report_mismatch("gain", 32'(resp.gain), 32'(want.gain));
                    if (resp.phase_centideg !== want.phase)
                        report_mismatch("phase", 32'(resp.phase_centideg), 32'(want.phase));
                    if (resp.status !== want.status)
                        report_mismatch("status", 32'(resp.status), 32'(want.status));
                    if (want.status)
                        unsupported_count++;
                end
                resp_count++;
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                resp.ready <= 1'b0;
            end
            else
            begin
                resp.ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lcbw_pkg::REG_FILTER_TYPE:  ladder_type = value[1:0];
            lcbw_pkg::REG_FILTER_ORDER: ladder_order = value[1:0];
            lcbw_pkg::REG_CUTOFF:       ladder_cutoff = value;
            lcbw_pkg::REG_TERMINATION:  ladder_term = value[15:0];
            default:                    ladder_bw = value;
        endcase
    endtask

    task automatic drain();
        wait (pending_probes.size() == 0 && !probe.valid && expected_resp.size() == 0);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_freq(input int sel);
        case (sel)
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd1000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(1, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_probe();
        int roll;
        longint unsigned c;
        longint unsigned v;
        roll = $urandom_range(9);
        c = (ladder_cutoff == 0) ? 1 : ladder_cutoff;
        if (roll < 3)
            return $urandom;
        if (roll < 4)
            return $urandom_range(0, 4096);
        // around the cutoff
        v = (c * $urandom_range(1, 64)) / 16;
        if (roll < 5)
            v = c + $urandom_range(0, 4) - 2;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    initial
    begin
        logic [31:0] directed [$];
        ladder_type = lcbw_pkg::FT_LOWPASS;
        ladder_order = lcbw_pkg::ORDER_2;
        ladder_cutoff = 32'd1000;
        ladder_term = 16'd50;
        ladder_bw = 32'd100;
        error_count = 0;
        resp_count = 0;
        unsupported_count = 0;
        phase_count = 0;
        idle_enable = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed probes at the reset ladder, then each type at order 3 at cutoff and extremes
        directed = '{32'd0, 32'd1, 32'd999, 32'd1000, 32'd1001, 32'd2000,
                     32'd100000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd500};
        foreach (directed[i])
            pending_probes.push_back(directed[i]);
        drain();
        for (int t = 0; t < 4; t++)
        begin
            write_reg(lcbw_pkg::REG_FILTER_TYPE, 32'(t));
            write_reg(lcbw_pkg::REG_FILTER_ORDER, {30'd0, lcbw_pkg::ORDER_3});
            write_reg(lcbw_pkg::REG_TERMINATION, 32'(16'hFFFF));
            pending_probes.push_back(32'd1000);
            pending_probes.push_back(32'd0);
            pending_probes.push_back(32'hFFFF_FFFF);
            drain();
        end
        write_reg(lcbw_pkg::REG_FILTER_ORDER, 32'd2);
        pending_probes.push_back(32'd1000);
        drain();
        write_reg(lcbw_pkg::REG_FILTER_ORDER, 32'd0);
        pending_probes.push_back(32'd77);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            idle_enable = (ph % 4) != 3;
            write_reg(lcbw_pkg::REG_FILTER_TYPE, 32'($urandom_range(3)));
            write_reg(lcbw_pkg::REG_FILTER_ORDER,
                      ($urandom_range(4) == 0) ? 32'($urandom_range(1))
                                               : 32'($urandom_range(2, 3)));
            write_reg(lcbw_pkg::REG_CUTOFF, pick_freq((ph < 4) ? ph : $urandom_range(2, 5)));
            write_reg(lcbw_pkg::REG_TERMINATION,
                      (ph == 0) ? 32'd0 : 32'($urandom_range(1, 65535)));
            write_reg(lcbw_pkg::REG_BANDWIDTH,
                      pick_freq((ph < 4) ? 3 - ph : $urandom_range(1, 5)));
            for (int k = 0; k < 32; k++)
                pending_probes.push_back(pick_probe());
            drain();
            phase_count++;
        end

        $display("checked %0d responses over %0d random ladder settings, %0d unsupported",
                 resp_count, phase_count, unsupported_count);
        $display("all four filter types at orders 0 to 3, extreme cutoffs and bandwidths");
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/lcbw_pkg.sv
src/lcbw_if.sv
src/lcbw_pipe.sv
src/lc_butterworth_response_unit.sv
src/lcbw_checker.sv
dv/tb_lc_butterworth_response_unit.sv
